FILE: src/sore_pkg.sv
// ----------------------------------------------------------------------------
// sore_pkg
// shared types, constants and sine/cosine table builder for the outline engine
// ----------------------------------------------------------------------------
package sore_pkg;

  localparam int IMAGE_SIZE_DEF = 256;
  localparam int ANGLE_STEPS    = 629;
  localparam int COORD_BITS     = 12;
  localparam int TRIG_W         = 18;   // signed q1.16
  localparam int FRAC           = 17;   // coordinate scale 2^17
  localparam int TAYLOR_ITERS   = 26;

  localparam logic [7:0] PIX_WHITE = 8'hFF;
  localparam logic [7:0] PIX_BLACK = 8'h00;

  localparam logic [63:0] Q56_ONE    = 64'd1 << 56;
  localparam logic [63:0] ONE_DIV100 = Q56_ONE / 64'd100;
  localparam logic [63:0] ONE_MOD100 = Q56_ONE % 64'd100;

  typedef enum logic [1:0] {
    OP_RECT = 2'd0,
    OP_OVAL = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_EDGE,
    ST_OVAL,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                           op;
    logic signed [COORD_BITS-1:0]  row_origin;
    logic signed [COORD_BITS-1:0]  col_origin;
    logic signed [COORD_BITS-1:0]  shape_height;
    logic signed [COORD_BITS-1:0]  shape_width;
    logic [7:0]                    read_row;
    logic [7:0]                    read_col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       was_read;
  } res_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

  // shift-subtract long division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor sum in unsigned q8.56, rounded to q1.16
  function automatic logic signed [TRIG_W-1:0] trig_q16(logic [63:0] k, bit odd);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] mag;
    logic [63:0] r;
    bit          neg;
    bit          sneg;
    t   = odd ? (ONE_DIV100 * k + udiv64(ONE_MOD100 * k, 64'd100)) : Q56_ONE;
    sum = t;
    n   = odd ? 64'd1 : 64'd0;
    neg = 1'b0;
    for (int it = 0; it < TAYLOR_ITERS; it++) begin
      t   = udiv64(t, 64'd100 * (n + 64'd1)) * k;
      t   = udiv64(t, 64'd100 * (n + 64'd2)) * k;
      n   = n + 64'd2;
      neg = !neg;
      sum = neg ? sum - t : sum + t;
    end
    sneg = sum[63];
    mag  = sneg ? (64'd0 - sum) : sum;
    r    = (mag + (64'd1 << 39)) >> 40;
    return sneg ? -TRIG_W'(r) : TRIG_W'(r);
  endfunction

  function automatic trig_tab_t build_tab(bit odd);
    trig_tab_t tab;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      tab[k] = trig_q16(64'(k), odd);
    end
    return tab;
  endfunction

endpackage

FILE: src/shape_outline_raster_engine.sv
// ----------------------------------------------------------------------------
// shape_outline_raster_engine
// one-bit image store with rectangle and ellipse outline drawing and pixel read
// ----------------------------------------------------------------------------
//  channel   | handshake     | payload
//  ----------+---------------+--------------------------------------------------
//  request   | push / full   | req_type, row_origin, col_origin, shape_height,
//            |               | shape_width, read_row, read_col
//  result    | empty / pop   | pixel_value, was_read
//
//  a rectangle draws its clipped edges through the single write port of the
//  image store, one pixel per cycle
//  an ellipse steps through ANGLE_STEPS angles, one angle per cycle through table
//  read, multiply and coordinate stages
//  after reset all 2**(2*clog2(IMAGE_SIZE)) store locations (65536 at the default)
//  are set white one pixel a cycle; requests queue meanwhile but are not run
//  two-entry queues on both sides let request and result transfers stall apart
// ----------------------------------------------------------------------------
module shape_outline_raster_engine #(
  parameter int IMAGE_SIZE = sore_pkg::IMAGE_SIZE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic [1:0]                             req_type,
  input  logic signed [sore_pkg::COORD_BITS-1:0] row_origin,
  input  logic signed [sore_pkg::COORD_BITS-1:0] col_origin,
  input  logic signed [sore_pkg::COORD_BITS-1:0] shape_height,
  input  logic signed [sore_pkg::COORD_BITS-1:0] shape_width,
  input  logic [7:0]                             read_row,
  input  logic [7:0]                             read_col,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [7:0]                             pixel_value,
  output logic                                   was_read
);
  import sore_pkg::*;

  // front to back command queue
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // back to result queue
  logic res_push;
  logic res_full;
  res_t res;

  // request decode and command queue
  sore_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .row_origin   (row_origin),
    .col_origin   (col_origin),
    .shape_height (shape_height),
    .shape_width  (shape_width),
    .read_row     (read_row),
    .read_col     (read_col),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // sequencer, image store and drawing datapaths
  sore_back #(
    .IMAGE_SIZE (IMAGE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue, one entry per request
  sore_res_q u_res_q (
    .clk         (clk),
    .rst         (rst),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full),
    .empty       (empty),
    .pop         (pop),
    .pixel_value (pixel_value),
    .was_read    (was_read)
  );

endmodule

FILE: src/sore_front.sv
// ----------------------------------------------------------------------------
// sore_front
// accepts requests, decodes the request type and queues commands
// ----------------------------------------------------------------------------
module sore_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       req_type,
  input  logic signed [sore_pkg::COORD_BITS-1:0] row_origin,
  input  logic signed [sore_pkg::COORD_BITS-1:0] col_origin,
  input  logic signed [sore_pkg::COORD_BITS-1:0] shape_height,
  input  logic signed [sore_pkg::COORD_BITS-1:0] shape_width,
  input  logic [7:0]                       read_row,
  input  logic [7:0]                       read_col,
  output logic                             cmd_valid,
  output sore_pkg::cmd_t                   cmd,
  input  logic                             cmd_pop
);
  import sore_pkg::*;

  cmd_t       entries [2];
  cmd_t       incoming;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    incoming.op           = op_t'(req_type);
    incoming.row_origin   = row_origin;
    incoming.col_origin   = col_origin;
    incoming.shape_height = shape_height;
    incoming.shape_width  = shape_width;
    incoming.read_row     = read_row;
    incoming.read_col     = read_col;
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= incoming;
    end
  end

endmodule

FILE: src/sore_back.sv
// ----------------------------------------------------------------------------
// sore_back
// command sequencer: image store, clearing pass, rectangle edges, ellipse pipe
// ----------------------------------------------------------------------------
module sore_back #(
  parameter int IMAGE_SIZE = sore_pkg::IMAGE_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  sore_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output sore_pkg::res_t res
);
  import sore_pkg::*;

  localparam int AW  = $clog2(IMAGE_SIZE);
  localparam int MAW = 2 * AW;
  localparam int EW  = (COORD_BITS + 2 > AW + 2) ? COORD_BITS + 2 : AW + 2;
  localparam int KW  = $clog2(ANGLE_STEPS);
  localparam int MW  = COORD_BITS + TRIG_W;
  localparam int SW  = MW + 1;
  localparam logic signed [EW-1:0] SIZE_S   = EW'(IMAGE_SIZE);
  // store is addressed {row, col}, so it spans the full power-of-two range
  localparam logic [MAW-1:0]       CLR_LAST = {MAW{1'b1}};
  localparam logic [KW-1:0]        K_LAST   = KW'(ANGLE_STEPS - 1);
  localparam logic [SW-1:0]        RND      = SW'((1 << FRAC) - 1);
  localparam trig_tab_t            SIN_TAB  = build_tab(1'b1);
  localparam trig_tab_t            COS_TAB  = build_tab(1'b0);

  state_t state, state_next;
  cmd_t   cur;

  logic [MAW-1:0] clr_addr;
  logic [1:0]     edge_idx;
  logic           e_vert;
  logic [AW-1:0]  e_fix;
  logic [AW:0]    e_cnt;
  logic [AW:0]    e_hi;
  logic           e_last;

  logic signed [EW-1:0] top_e, left_e, h_e, w_e;
  logic signed [EW-1:0] s_fix, s_start, s_len, s_end, s_lo, s_hi;
  logic                 s_vert;
  logic                 s_ok;

  logic [KW-1:0]            k_cnt;
  logic                     v1, v2;
  logic signed [TRIG_W-1:0] sin_q, cos_q;
  logic signed [MW-1:0]     px, py;
  logic signed [SW-1:0]     sx, sy, sxa, sya, qx, qy;
  logic signed [EW-1:0]     ox, oy;
  logic                     o_ok;

  logic           mem [1 << MAW];
  logic           we;
  logic           wdata;
  logic [MAW-1:0] waddr;
  logic [MAW-1:0] raddr;
  logic           rd_bit;
  logic           rd_in_range;

  // rectangle edge setup
  always_comb begin
    top_e  = EW'(cur.row_origin);
    left_e = EW'(cur.col_origin);
    h_e    = EW'(cur.shape_height);
    w_e    = EW'(cur.shape_width);
    case (edge_idx)
      2'd0: begin
        s_vert = 1'b1; s_fix = left_e; s_start = top_e; s_len = h_e;
      end
      2'd1: begin
        s_vert = 1'b1; s_fix = left_e + w_e - EW'(1); s_start = top_e; s_len = h_e;
      end
      2'd2: begin
        s_vert = 1'b0; s_fix = top_e; s_start = left_e; s_len = w_e;
      end
      default: begin
        s_vert = 1'b0; s_fix = top_e + h_e - EW'(1); s_start = left_e; s_len = w_e;
      end
    endcase
    s_end = s_start + s_len;
    s_lo  = (s_start < 0) ? '0 : s_start;
    s_hi  = (s_end > SIZE_S) ? SIZE_S : s_end;
    s_ok  = (s_fix >= 0) && (s_fix < SIZE_S) && (s_lo < s_hi);
  end

  assign e_last = ((e_cnt + (AW+1)'(1)) == e_hi);

  // ellipse coordinate, truncated toward zero
  always_comb begin
    sx  = (SW'(cur.col_origin) <<< FRAC) + SW'(px);
    sy  = (SW'(cur.row_origin) <<< FRAC) + SW'(py);
    sxa = sx + (sx[SW-1] ? RND : '0);
    sya = sy + (sy[SW-1] ? RND : '0);
    qx  = sxa >>> FRAC;
    qy  = sya >>> FRAC;
    ox  = EW'(qx);
    oy  = EW'(qy);
    o_ok = (ox >= 0) && (ox < SIZE_S) && (oy >= 0) && (oy < SIZE_S);
  end

  assign raddr       = {AW'(cur.read_row), AW'(cur.read_col)};
  assign rd_in_range = (int'(cur.read_row) < IMAGE_SIZE) && (int'(cur.read_col) < IMAGE_SIZE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_RECT: state_next = ST_SETUP;
            OP_OVAL: state_next = ST_OVAL;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SETUP: begin
        if (s_ok) state_next = ST_EDGE;
        else if (edge_idx == 2'd3) state_next = ST_DONE;
      end
      ST_EDGE: begin
        if (e_last) state_next = (edge_idx == 2'd3) ? ST_DONE : ST_SETUP;
      end
      ST_OVAL: begin
        if (k_cnt == K_LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2) state_next = ST_DONE;
      end
      ST_READ:  state_next = ST_DONE;
      ST_DONE: begin
        if (!res_full) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and write port
  always_comb begin
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    we              = 1'b0;
    wdata           = 1'b0;
    waddr           = '0;
    res.was_read    = (cur.op == OP_READ);
    res.pixel_value = (cur.op == OP_READ && rd_in_range && rd_bit) ? PIX_WHITE : PIX_BLACK;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = 1'b1;
        waddr = clr_addr;
      end
      ST_IDLE:  cmd_pop = cmd_valid;
      ST_EDGE: begin
        we    = 1'b1;
        waddr = e_vert ? {e_cnt[AW-1:0], e_fix} : {e_fix, e_cnt[AW-1:0]};
      end
      ST_DONE:  res_push = !res_full;
      default: ;
    endcase
    if (v2 && o_ok) begin
      we    = 1'b1;
      wdata = 1'b0;
      waddr = {oy[AW-1:0], ox[AW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + MAW'(1);
      v1 <= (state == ST_OVAL);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid) begin
      cur      <= cmd;
      edge_idx <= 2'd0;
      k_cnt    <= '0;
    end
    if (state == ST_SETUP) begin
      e_vert <= s_vert;
      e_fix  <= s_fix[AW-1:0];
      e_cnt  <= s_lo[AW:0];
      e_hi   <= s_hi[AW:0];
      if (!s_ok) edge_idx <= edge_idx + 2'd1;
    end
    if (state == ST_EDGE) begin
      e_cnt <= e_cnt + (AW+1)'(1);
      if (e_last) edge_idx <= edge_idx + 2'd1;
    end
    if (state == ST_OVAL) k_cnt <= k_cnt + KW'(1);
    sin_q <= SIN_TAB[k_cnt];
    cos_q <= COS_TAB[k_cnt];
    px    <= MW'(cur.shape_width)  * MW'(cos_q);
    py    <= MW'(cur.shape_height) * MW'(sin_q);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_bit <= mem[raddr];
  end

endmodule

FILE: src/sore_res_q.sv
// ----------------------------------------------------------------------------
// sore_res_q
// two-entry result queue in front of the result ports
// ----------------------------------------------------------------------------
module sore_res_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_push,
  input  sore_pkg::res_t res,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     pixel_value,
  output logic           was_read
);
  import sore_pkg::*;

  res_t       entries [2];
  res_t       head;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full    = (count == 2'd2);
  assign empty       = (count == 2'd0);
  assign head        = entries[rd_ptr];
  assign pixel_value = head.pixel_value;
  assign was_read    = head.was_read;
  assign do_push     = res_push && !res_full;
  assign do_pop      = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= res;
  end

endmodule

FILE: src/sore_chk.sv
// ----------------------------------------------------------------------------
// sore_chk
// port-level checks for the outline engine, bound to the top level
// ----------------------------------------------------------------------------
module sore_chk (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] pixel_value,
  input logic       was_read
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // every result value is black or white only
  a_pix_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pixel_value == 8'h00 || pixel_value == 8'hFF))
    else $error("pixel value not black or white");

  // draw and unknown-request completions carry zero
  a_draw_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !was_read) |-> (pixel_value == 8'h00))
    else $error("draw result with nonzero pixel value");

  // a waiting result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_value) && $stable(was_read)))
    else $error("result changed while stalled");

endmodule

bind shape_outline_raster_engine sore_chk u_chk (.*);

FILE: sim/tb_shape_outline_raster_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shape_outline_raster_engine
// self-checking bench: rectangle and ellipse outlines, pixel reads, random mix
// ----------------------------------------------------------------------------
// a local image model and its own q1.16 sine/cosine table predict each result
// requests and results both idle at random; results are checked in order
// ----------------------------------------------------------------------------
module tb_shape_outline_raster_engine;
  import sore_pkg::*;

  localparam int IMG = 256;
  localparam int CB  = COORD_BITS;

  typedef struct {
    logic [7:0] pixel_value;
    logic       was_read;
  } answer_t;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [1:0]           req_type;
  logic signed [CB-1:0] row_origin;
  logic signed [CB-1:0] col_origin;
  logic signed [CB-1:0] shape_height;
  logic signed [CB-1:0] shape_width;
  logic [7:0]           read_row;
  logic [7:0]           read_col;
  logic                 empty;
  logic                 pop;
  logic [7:0]           pixel_value;
  logic                 was_read;

  shape_outline_raster_engine uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .row_origin(row_origin), .col_origin(col_origin),
    .shape_height(shape_height), .shape_width(shape_width),
    .read_row(read_row), .read_col(read_col),
    .empty(empty), .pop(pop), .pixel_value(pixel_value), .was_read(was_read)
  );

  // model image, 1 = white
  bit      canvas [IMG*IMG];
  int      sin_q16 [ANGLE_STEPS];
  int      cos_q16 [ANGLE_STEPS];
  answer_t pending_answers [$];

  int errors;
  int n_rect, n_oval, n_read, n_black, n_checked;
  bit send_calm, pop_calm;
  int last_row, last_col;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // generous ceiling on the whole run
  initial begin
    #40ms;
    $display("timeout waiting for results");
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(string what, logic [7:0] got_v, logic got_r,
                        logic [7:0] exp_v, logic exp_r);
    errors++;
    $display("mismatch %s: got value %0d read %0b, expected value %0d read %0b",
             what, got_v, got_r, exp_v, exp_r);
  endtask

  // taylor sum in unsigned q8.56, rounded half away from zero to q1.16
  function automatic int angle_q16(longint unsigned k, bit odd);
    longint unsigned one;
    longint unsigned t;
    longint unsigned sum;
    longint unsigned n;
    longint unsigned mag;
    int              r;
    bit              flip;
    one  = 64'd1 << 56;
    t    = odd ? (one / 100) * k + ((one % 100) * k) / 100 : one;
    sum  = t;
    n    = odd ? 1 : 0;
    flip = 0;
    for (int i = 0; i < 26; i++) begin
      t    = t / (100 * (n + 1)) * k;
      t    = t / (100 * (n + 2)) * k;
      n    = n + 2;
      flip = !flip;
      sum  = flip ? sum - t : sum + t;
    end
    mag = sum[63] ? 64'd0 - sum : sum;
    r   = int'((mag + (64'd1 << 39)) >> 40);
    return sum[63] ? -r : r;
  endfunction

  function automatic void blacken(longint r, longint c);
    if (r >= 0 && r < IMG && c >= 0 && c < IMG) canvas[r*IMG + c] = 0;
  endfunction

  function automatic void edge_run(bit vertical, longint fixed_pos, longint start,
                                   longint len);
    longint lo;
    longint hi;
    lo = start < 0 ? 0 : start;
    hi = start + len > IMG ? IMG : start + len;
    if (fixed_pos < 0 || fixed_pos >= IMG) return;
    for (longint i = lo; i < hi; i++) begin
      if (vertical) blacken(i, fixed_pos);
      else blacken(fixed_pos, i);
    end
  endfunction

  // update the model image and work out the answer for one transfer
  function automatic answer_t predict_answer(logic [1:0] op, logic signed [CB-1:0] ro,
      logic signed [CB-1:0] co, logic signed [CB-1:0] h, logic signed [CB-1:0] w,
      logic [7:0] rr, logic [7:0] rc);
    answer_t a;
    longint  x;
    longint  y;
    a.pixel_value = PIX_BLACK;
    a.was_read    = 1'b0;
    case (op)
      OP_RECT: begin
        edge_run(1, longint'(co), longint'(ro), longint'(h));
        edge_run(1, longint'(co) + longint'(w) - 1, longint'(ro), longint'(h));
        edge_run(0, longint'(ro), longint'(co), longint'(w));
        edge_run(0, longint'(ro) + longint'(h) - 1, longint'(co), longint'(w));
      end
      OP_OVAL: begin
        for (int k = 0; k < ANGLE_STEPS; k++) begin
          x = (longint'(co) * 131072 + longint'(w) * longint'(cos_q16[k])) / 131072;
          y = (longint'(ro) * 131072 + longint'(h) * longint'(sin_q16[k])) / 131072;
          blacken(y, x);
        end
      end
      OP_READ: begin
        a.was_read = 1'b1;
        if (rr < IMG && rc < IMG)
          a.pixel_value = canvas[int'(rr)*IMG + int'(rc)] ? PIX_WHITE : PIX_BLACK;
      end
      default: ;
    endcase
    return a;
  endfunction

  // one request transfer after a random gap; push stays high if the next has none
  task automatic send_req(logic [1:0] op, int ro, int co, int h, int w, int rr, int rc);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push         = 1'b1;
    req_type     = op;
    row_origin   = CB'(ro);
    col_origin   = CB'(co);
    shape_height = CB'(h);
    shape_width  = CB'(w);
    read_row     = 8'(rr);
    read_col     = 8'(rc);
    do @(posedge clk); while (full !== 1'b0);
    pending_answers.push_back(predict_answer(req_type, row_origin, col_origin,
        shape_height, shape_width, read_row, read_col));
    case (op)
      OP_RECT: n_rect++;
      OP_OVAL: n_oval++;
      OP_READ: n_read++;
      default: ;
    endcase
  endtask

  task automatic read_px(int r, int c);
    send_req(OP_READ, 0, 0, 0, 0, r, c);
  endtask

  // result side: random pop gaps, compare each transfer with the oldest answer
  initial begin
    answer_t want;
    int      gap;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) pop_calm = !pop_calm;
      gap = pop_calm ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        pop = 1'b0;
      end
      @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      n_checked++;
      if (pending_answers.size() == 0) begin
        report("unexpected result", pixel_value, was_read, 8'h0, 1'b0);
      end else begin
        want = pending_answers.pop_front();
        if (was_read === 1'b1 && pixel_value === PIX_BLACK) n_black++;
        if (pixel_value !== want.pixel_value)
          report("pixel_value", pixel_value, was_read, want.pixel_value, want.was_read);
        if (was_read !== want.was_read)
          report("was_read", pixel_value, was_read, want.pixel_value, want.was_read);
      end
    end
  end

  task automatic test_white_after_reset();
    read_px(0, 0);
    read_px(255, 255);
    read_px(0, 255);
    read_px(128, 77);
  endtask

  task automatic test_rect_edges();
    send_req(OP_RECT, 0, 0, 256, 256, 0, 0);       // whole frame border
    read_px(0, 0);
    read_px(255, 255);
    read_px(255, 0);
    read_px(1, 1);
    send_req(OP_RECT, -10, -20, 50, 60, 0, 0);     // clipped at top left
    read_px(39, 10);
    read_px(30, 39);
    send_req(OP_RECT, 100, 100, 0, -5, 0, 0);      // empty dimensions
    send_req(OP_RECT, -2048, 2047, 2047, -2048, 0, 0);
    send_req(OP_RECT, 200, 200, 2047, 2047, 0, 0); // clipped at bottom right
    read_px(200, 250);
  endtask

  task automatic test_ellipse();
    send_req(OP_OVAL, 128, 128, 100, 160, 0, 0);
    read_px(128, 208);
    read_px(178, 128);
    send_req(OP_OVAL, 60, 60, -80, -40, 0, 0);     // mirrored by negative sizes
    send_req(OP_OVAL, 2047, -2048, 2047, -2048, 0, 0);
    read_px(60, 40);
  endtask

  task automatic test_unknown_req();
    send_req(OP_NONE, 5, 5, 10, 10, 5, 5);
    read_px(5, 5);
  endtask

  task automatic test_random_mix(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        last_row = $urandom_range(0, 340) - 40;
        last_col = $urandom_range(0, 340) - 40;
        send_req(OP_RECT, last_row, last_col, $urandom_range(0, 140) - 10,
                 $urandom_range(0, 140) - 10, $urandom, $urandom);
      end else if (pick < 30) begin
        last_row = $urandom_range(0, 300) - 20;
        last_col = $urandom_range(0, 300) - 20;
        send_req(OP_OVAL, last_row, last_col, $urandom_range(0, 400) - 200,
                 $urandom_range(0, 400) - 200, $urandom, $urandom);
      end else if (pick < 60) begin
        // near the last shape so black pixels turn up
        read_px((last_row + $urandom_range(0, 120)) & 8'hFF,
                (last_col + $urandom_range(0, 120)) & 8'hFF);
      end else if (pick < 88) begin
        read_px($urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 93) begin
        send_req(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        // full-width noise on every field
        send_req($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
      end
    end
  endtask

  initial begin
    errors = 0;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      sin_q16[k] = angle_q16(64'(k), 1);
      cos_q16[k] = angle_q16(64'(k), 0);
    end
    for (int i = 0; i < IMG*IMG; i++) canvas[i] = 1;
    rst          = 1'b1;
    push         = 1'b0;
    req_type     = OP_NONE;
    row_origin   = '0;
    col_origin   = '0;
    shape_height = '0;
    shape_width  = '0;
    read_row     = '0;
    read_col     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_white_after_reset();
    test_rect_edges();
    test_ellipse();
    test_unknown_req();
    test_random_mix(555);

    @(negedge clk);
    push = 1'b0;
    wait (pending_answers.size() == 0);
    repeat (1100) @(posedge clk);

    $display("covered %0d rectangles, %0d ellipses, %0d reads (%0d black)",
             n_rect, n_oval, n_read, n_black);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sore_pkg.sv
src/sore_front.sv
src/sore_back.sv
src/sore_res_q.sv
src/shape_outline_raster_engine.sv
src/sore_chk.sv
sim/tb_shape_outline_raster_engine.sv
